// ===== rtl/core/ufd_pkg.sv =====
// Package for the urlencoded form decoder: item types, result bundles,
// character constants and the character class helpers.
// No dependencies.
`default_nettype none

package ufd_pkg;

  // Result kinds
  localparam logic [2:0] KIND_KEY      = 3'd0;
  localparam logic [2:0] KIND_VAL      = 3'd1;
  localparam logic [2:0] KIND_KEY_DONE = 3'd2;
  localparam logic [2:0] KIND_VAL_DONE = 3'd3;
  localparam logic [2:0] KIND_ERR      = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_SYMBOL     = 3'd1;
  localparam logic [2:0] ERR_REPEAT_EQ  = 3'd2;
  localparam logic [2:0] ERR_AMP_IN_KEY = 3'd3;
  localparam logic [2:0] ERR_END_IN_KEY = 3'd4;

  // Escape progress
  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_FIRST = 2'd2;

  // Characters
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_body;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] kind;
    logic [2:0] error_code;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] kind;
    logic [2:0] error_code;
  } result_t;

  // All results caused by one body byte
  typedef struct packed {
    logic [2:0]                       cnt;
    result_t [MAX_RESULTS-1:0]        ent;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_allowed(input logic [7:0] c);
    logic ok;
    ok = is_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    case (c)
      8'h2D, 8'h5F, 8'h2E, 8'h7E, 8'h21, 8'h23, 8'h24, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D,
      8'h3F, 8'h40, 8'h5B, 8'h5D, 8'h25: ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Nibble of a hex digit; letters carry bit 6
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  // Append one result to a bundle
  function automatic bundle_t push_result(input bundle_t b, input logic [7:0] d,
                                          input logic [2:0] k, input logic [2:0] e);
    bundle_t r;
    r = b;
    r.ent[b.cnt[1:0]] = '{data_byte: d, kind: k, error_code: e};
    r.cnt = b.cnt + 3'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ufd_stream_if.sv =====
// Valid/ready stream channel carrying one payload per beat.
// Payload type is set by the instantiating scope.
`default_nettype none

interface ufd_stream_if #(parameter type payload_t = logic [7:0]) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ufd_front.sv =====
// Front end: accepts body bytes, tracks key/value and escape state, and
// builds the bundle of results for each byte. Uses ufd_pkg, ufd_stream_if.
`default_nettype none

module ufd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  ufd_stream_if.sink            body,
  input  wire logic             q_full,
  output      logic             push,
  output      ufd_pkg::bundle_t bundle
);
  import ufd_pkg::*;

  logic       in_value, in_value_next;
  logic [1:0] escape_count, escape_count_next;
  logic [7:0] first_escape_char, first_escape_char_next;
  logic       error_latched, error_latched_next;
  logic       accept;

  logic [7:0] c;
  logic       eob;
  logic [2:0] byte_kind;
  logic       errored;

  assign body.ready = !q_full;
  assign accept     = body.valid && body.ready;
  assign c          = body.data.in_byte;
  assign eob        = body.data.end_of_body;

  // Classify the byte and collect its results
  always_comb begin
    bundle_t b;
    b = '0;
    errored = 1'b0;
    in_value_next          = in_value;
    escape_count_next      = escape_count;
    first_escape_char_next = first_escape_char;
    error_latched_next     = error_latched;
    byte_kind = in_value ? KIND_VAL : KIND_KEY;

    if (error_latched) begin
      // drop bytes until the end of the body
    end else begin
      if (!is_allowed(c)) begin
        b = push_result(b, 8'h00, KIND_ERR, ERR_SYMBOL);
        errored = 1'b1;
        error_latched_next = 1'b1;
      end else if (escape_count == ESC_PCT) begin
        first_escape_char_next = c;
        escape_count_next      = ESC_FIRST;
      end else if (escape_count != ESC_NONE) begin
        if (is_hex(first_escape_char) && is_hex(c)) begin
          b = push_result(b, {hex_val(first_escape_char), hex_val(c)}, byte_kind, ERR_NONE);
        end else begin
          b = push_result(b, CH_PCT, byte_kind, ERR_NONE);
          b = push_result(b, first_escape_char, byte_kind, ERR_NONE);
          b = push_result(b, c, byte_kind, ERR_NONE);
        end
        escape_count_next = ESC_NONE;
      end else if (c == CH_PCT) begin
        escape_count_next = ESC_PCT;
      end else if (c == CH_EQ) begin
        if (in_value) begin
          b = push_result(b, 8'h00, KIND_ERR, ERR_REPEAT_EQ);
          errored = 1'b1;
          error_latched_next = 1'b1;
        end else begin
          b = push_result(b, 8'h00, KIND_KEY_DONE, ERR_NONE);
          in_value_next = 1'b1;
        end
      end else if (c == CH_AMP) begin
        if (!in_value) begin
          b = push_result(b, 8'h00, KIND_ERR, ERR_AMP_IN_KEY);
          errored = 1'b1;
          error_latched_next = 1'b1;
        end else begin
          b = push_result(b, 8'h00, KIND_VAL_DONE, ERR_NONE);
          in_value_next = 1'b0;
        end
      end else if (c == CH_PLUS) begin
        b = push_result(b, CH_SPACE, byte_kind, ERR_NONE);
      end else begin
        b = push_result(b, c, byte_kind, ERR_NONE);
      end

      // close the body: value done, or error when still in a key
      if (eob && !errored) begin
        if (in_value_next) begin
          b = push_result(b, 8'h00, KIND_VAL_DONE, ERR_NONE);
        end else begin
          b = push_result(b, 8'h00, KIND_ERR, ERR_END_IN_KEY);
        end
      end
    end

    // end of body returns everything to reset
    if (eob) begin
      in_value_next          = 1'b0;
      escape_count_next      = ESC_NONE;
      first_escape_char_next = 8'h00;
      error_latched_next     = 1'b0;
    end
    bundle = b;
  end

  assign push = accept && (bundle.cnt != 3'd0);

  // Advance parse state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_value          <= 1'b0;
      escape_count      <= ESC_NONE;
      first_escape_char <= 8'h00;
      error_latched     <= 1'b0;
    end else if (accept) begin
      in_value          <= in_value_next;
      escape_count      <= escape_count_next;
      first_escape_char <= first_escape_char_next;
      error_latched     <= error_latched_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && eob |=> !in_value && escape_count == ESC_NONE && !error_latched)
    else $error("state not cleared after end of body");

  a_latched_silent: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> !push)
    else $error("result produced while error latched");

  a_escape_range: assert property (@(posedge clk) disable iff (rst)
    escape_count != 2'd3)
    else $error("escape counter out of range");

endmodule

`default_nettype wire

// ===== rtl/core/ufd_queue.sv =====
// Short queue of result bundles between front and back.
// Uses ufd_pkg.
`default_nettype none

module ufd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ufd_pkg::bundle_t push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic             empty,
  output      ufd_pkg::bundle_t head
);
  import ufd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t        mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Store incoming bundles
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance");

endmodule

`default_nettype wire

// ===== rtl/core/ufd_back.sv =====
// Back end: walks each queued bundle one result a beat into a registered
// output stage. Uses ufd_pkg, ufd_stream_if.
`default_nettype none

module ufd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire ufd_pkg::bundle_t head,
  output      logic             pop,
  ufd_stream_if.source          result
);
  import ufd_pkg::*;

  logic [1:0] sub;
  logic       out_valid;
  out_item_t  out_data;
  logic       load;
  logic       last;

  assign load = !q_empty && (!out_valid || result.ready);
  assign last = ({1'b0, sub} == (head.cnt - 3'd1));
  assign pop  = load && last;

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Step through results of the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      sub       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        sub       <= last ? 2'd0 : sub + 2'd1;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the output beat until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_data.data_byte   <= head.ent[sub].data_byte;
      out_data.kind        <= head.ent[sub].kind;
      out_data.error_code  <= head.ent[sub].error_code;
      out_data.last_of_run <= last;
    end
  end

  a_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> ({1'b0, sub} < head.cnt))
    else $error("result index past bundle size");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_ERR |-> out_data.error_code == ERR_NONE)
    else $error("error code on non-error result");

  a_marks_carry_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == KIND_KEY_DONE || out_data.kind == KIND_VAL_DONE ||
                  out_data.kind == KIND_ERR) |-> out_data.data_byte == 8'h00)
    else $error("data byte on mark or error result");

endmodule

`default_nettype wire

// ===== rtl/core/urlencoded_form_decoder.sv =====
// Urlencoded form body decoder: one body byte per beat in, decoded bytes,
// key/value done marks and errors out, up to four results per byte.
// The first result of a byte passes through the queue and then the
// registered output stage before it is offered on result.
// Throughput: one byte per cycle while each byte gives at most one result
// and the output is taken; a byte with more results gives them one a beat.
// Reset (rst, synchronous): parse state cleared, queue and output emptied.
`default_nettype none

module urlencoded_form_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input wire logic     clk,
  input wire logic     rst,
  ufd_stream_if.sink   body,
  ufd_stream_if.source result
);
  import ufd_pkg::*;

  logic    push, pop, q_full, q_empty;
  bundle_t push_data, head;

  ufd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .body   (body),
    .q_full (q_full),
    .push   (push),
    .bundle (push_data)
  );

  ufd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  ufd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire
